>>> hdl/sfm_pkg.sv
package sfm_pkg;

    localparam int unsigned TABLE_DEPTH = 64;

    localparam int unsigned ETYPE_W   = 16;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned FLAGS_W   = 6;
    localparam int unsigned OPCODE_W  = 16;
    localparam int unsigned TOTAL_W   = 32;
    localparam int unsigned SRC_OUT_W = 7;

    localparam logic [ETYPE_W-1:0]  ETH_TYPE_ARP  = 16'h0806;
    localparam logic [OPCODE_W-1:0] ARP_OP_REPLY  = 16'd2;
    localparam logic [FLAGS_W-1:0]  FLAG_SYN_ONLY = 6'h02;

    typedef struct packed {
        logic [ETYPE_W-1:0]  eth_type;
        logic [ADDR_W-1:0]   source_address;
        logic [FLAGS_W-1:0]  tcp_flags;
        logic [OPCODE_W-1:0] arp_opcode;
    } t_item;

    typedef struct packed {
        logic [TOTAL_W-1:0]   syn_total;
        logic [SRC_OUT_W-1:0] distinct_sources;
        logic [TOTAL_W-1:0]   arp_reply_total;
        logic                 was_syn;
        logic                 new_source;
        logic                 table_full_drop;
    } t_result;

    // Increment that holds at the all-ones value.
    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] value);
        logic [TOTAL_W-1:0] res;
        if (&value) begin
            res = value;
        end else begin
            res = value + 1'b1;
        end
        return res;
    endfunction

endpackage

>>> hdl/sfm_cell.sv
// One entry of the source table. On an insert the cell takes the address of
// its upstream neighbor, so the newest address always sits in the first cell.
module sfm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [sfm_pkg::ADDR_W-1:0] i_shift_in,
    input  logic [sfm_pkg::ADDR_W-1:0] i_probe,
    input  logic                      i_live,
    output logic [sfm_pkg::ADDR_W-1:0] o_entry,
    output logic                      o_hit
);

    logic [sfm_pkg::ADDR_W-1:0] r_entry;
    logic                       r_hit;
    logic                       n_hit;

    assign n_hit = i_live && (r_entry == i_probe);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

>>> hdl/syn_flood_and_arp_reply_monitor.sv
// Channel   | Handshake         | Payload                  | Direction
// ----------+-------------------+--------------------------+----------
// item in   | start, busy       | i_item   (t_item)        | input
// result    | o_valid (strobe)  | o_result (t_result)      | output
//
// In the cycle an item is accepted, every cell compares
// its stored address with the incoming source address and registers a hit.
// In the following cycle busy is high: the hits are ORed, the counters and
// the table are updated, and the result is registered. The result strobe
// lies in the next cycle, in which a new item may already be accepted.
// Reset is synchronous and active low; it clears the counters, the fill
// count and the control state. The table contents need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
module syn_flood_and_arp_reply_monitor #(
    parameter int unsigned TABLE_DEPTH = sfm_pkg::TABLE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sfm_pkg::t_item   i_item,
    output logic             o_valid,
    output sfm_pkg::t_result o_result
);

    // The fill count must be able to hold the depth itself.
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    // Two states: waiting for an item, and updating with the item taken.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    sfm_pkg::t_item               r_item;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [sfm_pkg::TOTAL_W-1:0]  r_syn_cnt;
    logic [sfm_pkg::TOTAL_W-1:0]  n_syn_cnt;
    logic [sfm_pkg::TOTAL_W-1:0]  r_arp_cnt;
    logic [sfm_pkg::TOTAL_W-1:0]  n_arp_cnt;
    logic                         r_valid;
    sfm_pkg::t_result             r_result;
    sfm_pkg::t_result             n_result;

    logic                         w_accept;
    logic                         w_updating;
    logic                         w_syn;
    logic                         w_known;
    logic                         w_full;
    logic                         w_insert;
    logic                         w_drop;
    logic                         w_arp_reply;
    logic [CNT_W+sfm_pkg::SRC_OUT_W-1:0] w_count_wide;

    logic [TABLE_DEPTH-1:0]       w_hit;
    logic [TABLE_DEPTH-1:0]       w_live;
    logic [sfm_pkg::ADDR_W-1:0]   w_entry [TABLE_DEPTH];

    assign w_updating = (r_state == S_UPD);
    assign busy       = w_updating;
    assign w_accept   = start && !busy;

    // The chain of cells. Cells below the fill count hold stored addresses;
    // a cell at or beyond it never reports a hit. The incoming address is
    // compared in every cell as the item is accepted.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [sfm_pkg::ADDR_W-1:0] w_shift_in;

        if (g == 0) begin : g_head
            assign w_shift_in = r_item.source_address;
        end else begin : g_body
            assign w_shift_in = w_entry[g-1];
        end

        assign w_live[g] = (r_count > CNT_W'(g));

        sfm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_insert),
            .i_shift_in (w_shift_in),
            .i_probe    (i_item.source_address),
            .i_live     (w_live[g]),
            .o_entry    (w_entry[g]),
            .o_hit      (w_hit[g])
        );
    end

    // Classification of the item held during the update cycle.
    assign w_syn       = (r_item.tcp_flags == sfm_pkg::FLAG_SYN_ONLY);
    assign w_known     = |w_hit;
    assign w_full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_insert    = w_updating && w_syn && !w_known && !w_full;
    assign w_drop      = w_syn && !w_known && w_full;
    assign w_arp_reply = (r_item.eth_type == sfm_pkg::ETH_TYPE_ARP) &&
                         (r_item.arp_opcode == sfm_pkg::ARP_OP_REPLY);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_syn_cnt = r_syn_cnt;
        n_arp_cnt = r_arp_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_IDLE;
                if (w_syn) begin
                    n_syn_cnt = sfm_pkg::sat_inc(r_syn_cnt);
                end
                if (w_insert) begin
                    n_count = CNT_W'(r_count + 1'b1);
                end
                if (w_arp_reply) begin
                    n_arp_cnt = sfm_pkg::sat_inc(r_arp_cnt);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The reported count is the low bits of the fill count, zero-extended
    // first when the count is narrower than the field.
    assign w_count_wide = {{sfm_pkg::SRC_OUT_W{1'b0}}, n_count};

    always_comb begin
        n_result.syn_total        = n_syn_cnt;
        n_result.distinct_sources = w_count_wide[sfm_pkg::SRC_OUT_W-1:0];
        n_result.arp_reply_total  = n_arp_cnt;
        n_result.was_syn          = w_syn;
        n_result.new_source       = w_insert;
        n_result.table_full_drop  = w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_syn_cnt <= '0;
            r_arp_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_syn_cnt <= n_syn_cnt;
            r_arp_cnt <= n_arp_cnt;
            r_valid   <= w_updating;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (w_updating) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // An accepted item always leads to the update cycle next.
    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter the update cycle");

    // The update cycle is always followed by exactly one result strobe.
    a_update_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("update cycle not followed by a result");

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // Insert and drop exclude each other and only follow a pure SYN.
    a_flag_consistency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!(o_result.new_source && o_result.table_full_drop) &&
                     (o_result.was_syn || !(o_result.new_source ||
                                            o_result.table_full_drop))))
        else $error("inconsistent insert and drop flags");

    // A drop is only reported while the table is full.
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && w_drop) |-> (r_count == CNT_W'(TABLE_DEPTH)))
        else $error("drop reported with room left in the table");

endmodule
